@@ rtl/bfa_pkg.sv @@
package bfa_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_BLOCKS_D  = 64;
  localparam int unsigned PAGE_BYTES_D  = 16384;  // power of two
  localparam int unsigned FRAME_PAGES_D = 4;

  // requests of this rounded size or more are page aligned
  localparam logic [26:0] ALIGN_LIMIT = 27'd49152;
  // best-gap start value: a gap must be below 32 MiB to win
  localparam logic signed [29:0] NO_FIT = 30'sd33554432;

  // request kinds (in_tuser)
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_LOCK  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_BAD_HND   = 3'd3;
  localparam logic [2:0] ST_PAST_END  = 3'd4;

  // configuration register indexes
  localparam logic CFG_HEAP_READY = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  // one table entry, held by one cell
  typedef struct packed {
    logic [25:0] start;
    logic [25:0] size;
    logic [15:0] handle;
  } entry_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [15:0] granted_length;
    logic [2:0]  page_count;
    logic [10:0] first_page;
    logic [13:0] window_offset;
    logic [24:0] block_base;
    logic [15:0] new_handle;
    logic [2:0]  result_status;
  } result_t;

endpackage

@@ rtl/best_fit_block_allocator.sv @@
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_tvalid / in_tready  | tuser: mode; tdata: size, id, offset, length
// out_    | out | out_tvalid / out_tready| tdata: status, handle, base, window, pages, length
// cfg_    | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Allocate and free pass through the scan and finish states, a granted lock also
// through S_LOCK2, before the result is loaded; the table rotates once through the
// row of cells so cell 0 shows every entry in order. Requests refused up front
// go straight to S_DONE. Reset empties the table and the handle counter at once.
// A new beat is taken only in idle; a stalled result waits in the output register.
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = bfa_pkg::MAX_BLOCKS_D,
  parameter int unsigned PAGE_BYTES  = bfa_pkg::PAGE_BYTES_D,
  parameter int unsigned FRAME_PAGES = bfa_pkg::FRAME_PAGES_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [87:0] in_tdata,   // request_size, block_id, lock_offset, lock_length, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // result_status, new_handle, block_base, window_offset,
                                  // first_page, page_count, granted_length
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [25:0] cfg_wdata
);
  import bfa_pkg::*;

  localparam int unsigned PW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PG_SH = $clog2(PAGE_BYTES);
  localparam logic [27:0] PG_M1 = 28'(PAGE_BYTES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_LOCK2, S_DONE} state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [15:0]     hcnt_r;
  logic            ready_r;
  logic [25:0]     hbytes_r;
  logic [PW-1:0]   k_r;
  logic [1:0]      mode_r;
  logic [26:0]     size_r;
  logic            align_r;
  logic [15:0]     id_r;
  logic [25:0]     off_r;
  logic [15:0]     len_r;
  logic [27:0]     prev_base_r;
  logic signed [29:0] best_r;
  logic [27:0]     best_base_r;
  logic            found_r;
  logic [PW-1:0]   pos_r;
  logic [25:0]     rec_start_r;
  logic [25:0]     rec_size_r;
  logic [15:0]     glen_r;
  logic [26:0]     addr_r;
  result_t         res_r;
  result_t         out_data_r;
  logic            out_valid_r;
  logic            out_load;

  // row of cells
  entry_t   cells [MAX_BLOCKS];
  entry_t   new_entry;
  cell_op_t cell_op;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    bfa_cell #(.IDX(i), .PW(PW)) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .pos     (pos_r),
      .prev_in (cells[(i + MAX_BLOCKS - 1) % MAX_BLOCKS]),
      .next_in (cells[(i + 1) % MAX_BLOCKS]),
      .new_in  (new_entry),
      .ent_out (cells[i])
    );
  end

  // input fields
  logic [25:0] f_size, f_off;
  logic [15:0] f_id, f_len;
  logic [26:0] f_round;
  assign f_size  = in_tdata[25:0];
  assign f_id    = in_tdata[41:26];
  assign f_off   = in_tdata[67:42];
  assign f_len   = in_tdata[83:68];
  assign f_round = (27'(f_size) + 27'd15) & ~27'd15;

  // scan step on the entry in cell 0
  entry_t head;
  logic in_range, at_tail, fit, hit, last_k;
  logic [25:0] nstart;
  logic signed [29:0] gap;
  logic [27:0] hend, hup, hbase;
  assign head     = cells[0];
  assign in_range = CW'(k_r) < count_r;
  assign at_tail  = CW'(k_r) == count_r;
  assign nstart   = in_range ? head.start : hbytes_r;
  assign gap      = $signed({4'b0, nstart}) - $signed({2'b0, prev_base_r});
  assign fit      = (in_range || at_tail) && (gap > $signed({3'b0, size_r})) && (gap < best_r);
  assign hit      = in_range && !found_r && (id_r != 16'd0) && (head.handle == id_r);
  assign hend     = 28'(head.start) + 28'(head.size);
  assign hup      = (hend + PG_M1) & ~PG_M1;
  assign hbase    = align_r ? hup : hend;
  assign last_k   = k_r == PW'(MAX_BLOCKS - 1);

  // next handle skips zero
  logic [15:0] hnext;
  assign hnext = (hcnt_r == 16'hFFFF) ? 16'd1 : hcnt_r + 16'd1;
  assign new_entry = '{start: best_base_r[25:0], size: size_r[25:0], handle: hnext};

  // cell command
  always_comb begin
    cell_op = CELL_HOLD;
    if (state_r == S_SCAN) cell_op = CELL_ROT;
    else if (state_r == S_FIN && found_r && mode_r == MODE_ALLOC) cell_op = CELL_INS;
    else if (state_r == S_FIN && found_r && mode_r == MODE_FREE) cell_op = CELL_DEL;
  end

  // lock window math
  logic [26:0] lreq;
  logic [31:0] woff32, page32, pc32;
  logic [2:0]  pcnt;
  assign lreq   = 27'(len_r) + 27'(off_r);
  assign woff32 = 32'(addr_r) & 32'(PAGE_BYTES - 1);
  assign page32 = 32'(addr_r >> PG_SH);
  assign pc32   = (32'(glen_r) + woff32 + 32'(PAGE_BYTES - 1)) >> PG_SH;
  always_comb begin
    if (pc32 == 32'd0) pcnt = 3'd1;
    else if (pc32 > 32'(FRAME_PAGES)) pcnt = 3'(FRAME_PAGES);
    else pcnt = pc32[2:0];
  end

  // result moves to the output register when it is free or being taken
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // controller, table bookkeeping and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hcnt_r      <= '0;
      ready_r     <= 1'b0;
      hbytes_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEAP_READY: ready_r  <= cfg_wdata[0];
          CFG_HEAP_BYTES: hbytes_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r      <= in_tuser;
            size_r      <= f_round;
            align_r     <= f_round >= ALIGN_LIMIT;
            id_r        <= f_id;
            off_r       <= f_off;
            len_r       <= f_len;
            k_r         <= '0;
            prev_base_r <= '0;
            best_r      <= NO_FIT;
            found_r     <= 1'b0;
            if (!ready_r) begin
              res_r   <= result_t'(88'(ST_NOT_READY));
              state_r <= S_DONE;
            end else if (in_tuser == MODE_ALLOC && count_r >= CW'(MAX_BLOCKS)) begin
              res_r   <= result_t'(88'(ST_NO_MEM));
              state_r <= S_DONE;
            end else if (in_tuser != MODE_ALLOC && in_tuser != MODE_FREE &&
                         in_tuser != MODE_LOCK) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              res_r   <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mode_r == MODE_ALLOC) begin
            if (fit) begin
              best_r      <= gap;
              best_base_r <= prev_base_r;
              pos_r       <= k_r;
              found_r     <= 1'b1;
            end
            if (in_range) prev_base_r <= hbase;
          end else if (hit) begin
            found_r     <= 1'b1;
            pos_r       <= k_r;
            rec_start_r <= head.start;
            rec_size_r  <= head.size;
          end
          k_r <= k_r + 1'b1;
          if (last_k) state_r <= S_FIN;
        end
        S_FIN: begin
          if (mode_r == MODE_ALLOC) begin
            state_r <= S_DONE;
            if (found_r) begin
              count_r                <= count_r + 1'b1;
              hcnt_r                 <= hnext;
              res_r.new_handle       <= hnext;
              res_r.block_base       <= best_base_r[24:0];
            end else begin
              res_r.result_status <= ST_NO_MEM;
            end
          end else if (!found_r) begin
            state_r <= S_DONE;
            res_r.result_status <= ST_BAD_HND;
          end else if (mode_r == MODE_FREE) begin
            state_r <= S_DONE;
            count_r <= count_r - 1'b1;
          end else if (off_r > rec_size_r) begin
            state_r <= S_DONE;
            res_r.result_status <= ST_PAST_END;
          end else begin
            glen_r  <= (lreq > 27'(rec_size_r)) ? 16'(rec_size_r - off_r) : len_r;
            addr_r  <= 27'(rec_start_r) + 27'(off_r);
            state_r <= S_LOCK2;
          end
        end
        S_LOCK2: begin
          res_r.window_offset  <= woff32[13:0];
          res_r.first_page     <= page32[10:0];
          res_r.page_count     <= pcnt;
          res_r.granted_length <= glen_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r  <= res_r;
            found_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // table never holds more than its depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BLOCKS)) else $error("entry count past table depth");

  // a successful allocate grows the table by one
  a_alloc_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && mode_r == MODE_ALLOC && found_r) |=>
      count_r == $past(count_r) + 1'b1) else $error("allocate did not add an entry");

  // scan does not finish before one full table rotation
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !last_k) |=> state_r == S_SCAN) else $error("scan cut short");

  // result codes stay in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.result_status <= ST_PAST_END) else $error("bad status code");

endmodule

@@ rtl/bfa_cell.sv @@
module bfa_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 6
) (
  input  logic              clk,
  input  bfa_pkg::cell_op_t op,
  input  logic [PW-1:0]     pos,
  input  bfa_pkg::entry_t   prev_in,
  input  bfa_pkg::entry_t   next_in,
  input  bfa_pkg::entry_t   new_in,
  output bfa_pkg::entry_t   ent_out
);
  import bfa_pkg::*;

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  entry_t ent_r;

  // rotate toward cell 0, open a slot, or close one
  always_ff @(posedge clk) begin
    case (op)
      CELL_ROT: ent_r <= next_in;
      CELL_INS: begin
        if (MY_POS > pos) ent_r <= prev_in;
        else if (MY_POS == pos) ent_r <= new_in;
      end
      CELL_DEL: begin
        if (MY_POS >= pos) ent_r <= next_in;
      end
      default: ;
    endcase
  end

  assign ent_out = ent_r;

endmodule
